FILE: sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants for the coprime table builder: table geometry, register
// map and action codes.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int MAX_SIZE = 64;
  localparam int ROW_W    = 64;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SIZE_W   = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  localparam logic REG_SIZE_IN_USE = 1'b0;

  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_READ  = 1'b1;

endpackage

FILE: sv/cpt_ram.sv
// ----------------------------------------------------------------------------
// cpt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/coprime_table_builder.sv
// ----------------------------------------------------------------------------
// coprime_table_builder
// Keeps a square bit table of coprime index pairs and answers cell reads.
//
// A word is accepted when start is high and busy is low. With in_action set
// to read, the cell (in_row_index, in_col_index) is returned in the next
// cycle on out_coprime_bit with out_strobe high; reads are accepted every
// cycle while busy is low. Indices at or beyond the configured size read 0,
// as does the whole table before the first build. With in_action set to
// build, busy rises and a sieve rebuilds the table in the row memory: every
// row is written, each candidate p below the configured size is checked,
// and for each prime p the column mask is formed and the rows that are
// multiples of p are read, modified and written back through the single
// read and write port. One word with out_build_done high ends the build;
// busy stays high through that cycle and falls after it. Results are shown
// for a single cycle and cannot be held off. The user must write the size
// register via the APB port only while idle; the block does not enforce it.
// Reset restores size 64, marks the table empty and leaves the block idle.
// ----------------------------------------------------------------------------
module coprime_table_builder
  import cpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [IDX_W-1:0]   in_row_index,
  input  logic [IDX_W-1:0]   in_col_index,
  output logic               out_strobe,
  output logic               out_coprime_bit,
  output logic               out_build_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_NEXT_P,
    S_CHECK,
    S_MASK,
    S_WALK_RD,
    S_WALK_WR,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]   r_r, r_nxt;
  logic [ROW_W-1:0]   strike_r, strike_nxt;
  logic               table_ok_r, table_ok_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [IDX_W-1:0]   rd_col_r, rd_col_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;

  logic               cfg_wr;
  logic               accept;
  logic [CNT_W-1:0]   n_now;
  logic [ROW_W-1:0]   fill_mask;

  cpt_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SIZE)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? PDATA_W'(size_r) : '0;

  assign busy   = (state_r != S_IDLE);
  assign accept = start & ~busy;
  assign n_now  = (size_r > SIZE_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : CNT_W'(size_r);

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      fill_mask[j] = (j != 0) && (CNT_W'(j) < n_r);
    end
  end

  assign out_strobe      = rd_pend_r | (state_r == S_DONE);
  assign out_coprime_bit = rd_pend_r & rd_ok_r & ram_rdata[rd_col_r];
  assign out_build_done  = (state_r == S_DONE);

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    n_nxt        = n_r;
    p_nxt        = p_r;
    r_nxt        = r_r;
    strike_nxt   = strike_r;
    table_ok_nxt = table_ok_r;
    rd_pend_nxt  = 1'b0;
    rd_ok_nxt    = rd_ok_r;
    rd_col_nxt   = rd_col_r;
    ram_we       = 1'b0;
    ram_waddr    = r_r[IDX_W-1:0];
    ram_wdata    = '0;
    ram_raddr    = in_row_index;

    if (cfg_wr && (paddr[2] == REG_SIZE_IN_USE)) begin
      size_nxt = pwdata[SIZE_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_READ) begin
            rd_pend_nxt = 1'b1;
            rd_col_nxt  = in_col_index;
            rd_ok_nxt   = table_ok_r && (CNT_W'(in_row_index) < n_now) &&
                          (CNT_W'(in_col_index) < n_now);
          end else begin
            n_nxt     = n_now;
            r_nxt     = '0;
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = ((r_r != '0) && (r_r < n_r)) ? fill_mask : '0;
        r_nxt     = r_r + CNT_W'(1);
        if (r_r == CNT_W'(MAX_SIZE - 1)) begin
          table_ok_nxt = 1'b1;
          p_nxt        = CNT_W'(2);
          state_nxt    = S_NEXT_P;
        end
      end
      S_NEXT_P: begin
        ram_raddr = p_r[IDX_W-1:0];
        if (p_r >= n_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ram_rdata[p_r[IDX_W-1:0]]) begin
          strike_nxt = '0;
          r_nxt      = p_r;
          state_nxt  = S_MASK;
        end else begin
          p_nxt     = p_r + CNT_W'(1);
          state_nxt = S_NEXT_P;
        end
      end
      S_MASK: begin
        if (r_r < n_r) begin
          strike_nxt = strike_r | (ROW_W'(1) << r_r[IDX_W-1:0]);
          r_nxt      = r_r + p_r;
        end else begin
          r_nxt     = p_r;
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        ram_raddr = r_r[IDX_W-1:0];
        if (r_r < n_r) begin
          state_nxt = S_WALK_WR;
        end else begin
          p_nxt     = p_r + CNT_W'(1);
          state_nxt = S_NEXT_P;
        end
      end
      S_WALK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~strike_r;
        r_nxt     = r_r + p_r;
        state_nxt = S_WALK_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      size_r     <= SIZE_RESET;
      table_ok_r <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      table_ok_r <= table_ok_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    r_r      <= r_nxt;
    strike_r <= strike_nxt;
    rd_ok_r  <= rd_ok_nxt;
    rd_col_r <= rd_col_nxt;
  end

  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_READ)) |=> (out_strobe && !out_build_done))
    else $error("read word not answered in the next cycle");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_build_done |=> !busy)
    else $error("block still busy after build completion");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("row memory written while idle");

  a_bit_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_coprime_bit |-> (out_strobe && !out_build_done))
    else $error("coprime bit raised outside a read result");

endmodule
